### rtl/core/uart_baud_divisor_calc_top_assert.svh
// ----------------------------------------------------------------------------
// UART baud divisor calculator - assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef UART_BAUD_DIVISOR_CALC_TOP_ASSERT_SVH
`define UART_BAUD_DIVISOR_CALC_TOP_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define UBDC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ubdc: same-cycle check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define UBDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ubdc: next-cycle check failed");

`endif

### rtl/core/ubdc_pkg.sv
// ----------------------------------------------------------------------------
// UART baud divisor calculator package
// Widths, codes and the data word that travels down the divider chain.
// ----------------------------------------------------------------------------
package ubdc_pkg;

    localparam int BAUD_W  = 24;
    localparam int CLK_W   = 32;
    localparam int WORD_W  = 16;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 8;
    // Dividend is 2*clock + baud, divisor is 2*baud.
    localparam int NUM_W   = CLK_W + 2;
    localparam int DVS_W   = BAUD_W + 1;
    localparam int REM_W   = DVS_W;

    localparam logic [CLK_W-1:0] CLOCK_HZ_RST = 32'd16000000;

    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERSAMPLE = 8'd1;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO_BAUD = 2'd1;
    localparam logic [STAT_W-1:0] ST_SATURATED = 2'd2;

    localparam logic [WORD_W-1:0] WORD_MAX = 16'hFFFF;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic [DVS_W-1:0] dvs;
        logic [NUM_W-1:0] quo;
        logic             zero;
        logic             by8;
    } t_cell_data;

endpackage

### rtl/core/ubdc_div_cell.sv
// ----------------------------------------------------------------------------
// UART baud divisor calculator - divider cell
// One restoring-division step: resolves one quotient bit and hands on.
// ----------------------------------------------------------------------------
module ubdc_div_cell
    import ubdc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cell_data i_data,
    output logic       o_ready,
    output logic       o_valid,
    output t_cell_data o_data,
    input  logic       i_ready_next
);

    logic             r_valid;
    t_cell_data       r_data;
    t_cell_data       n_data;
    logic [REM_W:0]   w_trial;
    logic [REM_W:0]   w_diff;
    logic             w_ge;

    // Shift in the next dividend bit and try to subtract the divisor.
    always_comb begin
        w_trial = {i_data.rem, i_data.num[NUM_W-1]};
        w_diff  = w_trial - {1'b0, i_data.dvs};
        w_ge    = (w_trial >= {1'b0, i_data.dvs});
        n_data      = i_data;
        n_data.rem  = w_ge ? w_diff[REM_W-1:0] : w_trial[REM_W-1:0];
        n_data.num  = {i_data.num[NUM_W-2:0], 1'b0};
        n_data.quo  = {i_data.quo[NUM_W-2:0], w_ge};
    end

    // Load whenever this slot is empty or its content moves on.
    assign o_ready = !r_valid || i_ready_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/core/ubdc_out_stage.sv
// ----------------------------------------------------------------------------
// UART baud divisor calculator - output stage
// Packs mantissa and fraction, flags zero baud and saturation, holds result.
// ----------------------------------------------------------------------------
module ubdc_out_stage
    import ubdc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_cell_data        i_data,
    output logic              o_ready,
    output logic              o_valid,
    output logic [WORD_W-1:0] o_word,
    output logic [STAT_W-1:0] o_stat,
    input  logic              i_ready_next
);

    logic              r_valid;
    logic [WORD_W-1:0] r_word;
    logic [STAT_W-1:0] r_stat;
    logic [WORD_W-1:0] n_word;
    logic [STAT_W-1:0] n_stat;
    logic              w_over;

    // Quotient is round(clock / baud) in units of one fraction step.
    always_comb begin
        if (i_data.by8) begin
            w_over = |i_data.quo[NUM_W-1:WORD_W-1];
            n_word = {i_data.quo[WORD_W-2:3], 1'b0, i_data.quo[2:0]};
        end else begin
            w_over = |i_data.quo[NUM_W-1:WORD_W];
            n_word = i_data.quo[WORD_W-1:0];
        end
        n_stat = ST_OK;
        if (i_data.zero) begin
            n_word = '0;
            n_stat = ST_ZERO_BAUD;
        end else if (w_over) begin
            n_word = WORD_MAX;
            n_stat = ST_SATURATED;
        end
    end

    assign o_ready = !r_valid || i_ready_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_word <= n_word;
            r_stat <= n_stat;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
    assign o_stat  = r_stat;

endmodule

### rtl/core/uart_baud_divisor_calc_top.sv
// Datapath: an accepted transaction loads the first of 34 divider cells,
//   one per quotient bit; the last cell hands on to the output register.
// Throughput: one transaction per cycle while the chain is not stalled;
//   every cell is an independent slot, so the chain keeps filling while a
//   finished result waits to be taken.
// Reset: synchronous, active low; empties the chain and restores the clock
//   to 16 MHz and oversampling to 16.
// ----------------------------------------------------------------------------
// UART baud divisor calculator - top level
// Turns a requested baud rate into a packed mantissa/fraction baud word.
// ----------------------------------------------------------------------------
module uart_baud_divisor_calc_top
    import ubdc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CLK_W-1:0]     i_cfg_data,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [BAUD_W-1:0]    i_requested_baud,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [WORD_W-1:0]    o_divisor_word,
    output logic [STAT_W-1:0]    o_status
);

    // Configuration registers.
    logic [CLK_W-1:0] r_clock_hz;
    logic             r_by8;

    // Links between neighboring cells; slot k feeds cell k.
    logic       w_valid [NUM_W+1];
    logic       w_ready [NUM_W+1];
    t_cell_data w_data  [NUM_W+1];
    t_cell_data w_head;

    // Configuration writes are always taken; unknown indexes drop.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= CLOCK_HZ_RST;
            r_by8      <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CLOCK_HZ:   r_clock_hz <= i_cfg_data;
                CFG_OVERSAMPLE: r_by8      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Form the rounding division round(clock / baud) as
    // (2*clock + baud) / (2*baud); the fraction then falls out of the
    // low quotient bits and a fraction carry reaches the mantissa by itself.
    // Latch the oversampling mode with the transaction.
    always_comb begin
        w_head.rem  = '0;
        w_head.num  = {1'b0, r_clock_hz, 1'b0}
                    + {{(NUM_W-BAUD_W){1'b0}}, i_requested_baud};
        w_head.dvs  = {i_requested_baud, 1'b0};
        w_head.quo  = '0;
        w_head.zero = (i_requested_baud == '0);
        w_head.by8  = r_by8;
    end

    assign w_data[0]  = w_head;
    assign w_valid[0] = i_in_valid;
    assign o_in_ready = w_ready[0];

    // Chain of divider cells, most significant quotient bit first.
    for (genvar k = 0; k < NUM_W; k++) begin : g_cell
        ubdc_div_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_valid      (w_valid[k]),
            .i_data       (w_data[k]),
            .o_ready      (w_ready[k]),
            .o_valid      (w_valid[k+1]),
            .o_data       (w_data[k+1]),
            .i_ready_next (w_ready[k+1])
        );
    end

    // Pack, flag and hold the result until the transaction completes.
    ubdc_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_valid[NUM_W]),
        .i_data       (w_data[NUM_W]),
        .o_ready      (w_ready[NUM_W]),
        .o_valid      (o_out_valid),
        .o_word       (o_divisor_word),
        .o_stat       (o_status),
        .i_ready_next (i_out_ready)
    );

endmodule

### rtl/core/ubdc_checker.sv
// ----------------------------------------------------------------------------
// UART baud divisor calculator - port checker
// Watches the top-level ports for malformed results and dropped stalls.
// ----------------------------------------------------------------------------
`include "uart_baud_divisor_calc_top_assert.svh"

module ubdc_checker
    import ubdc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [WORD_W-1:0]    o_divisor_word,
    input logic [STAT_W-1:0]    o_status
);

    // A zero-baud flag always comes with an empty word.
    `UBDC_ASSERT_IMPLY(a_zero_word, o_out_valid && o_status == ST_ZERO_BAUD, o_divisor_word == '0)
    // Saturation always pins the word at full scale.
    `UBDC_ASSERT_IMPLY(a_sat_word, o_out_valid && o_status == ST_SATURATED, o_divisor_word == WORD_MAX)
    // Only the three defined codes appear.
    `UBDC_ASSERT_IMPLY(a_status_code, o_out_valid, o_status <= ST_SATURATED)
    // Hold a stalled result.
    `UBDC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable({o_divisor_word, o_status}))

endmodule

bind uart_baud_divisor_calc_top ubdc_checker u_checker (.*);
